@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge, reset gated
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tra_pkg.sv @@
// ---------------------------------------------------------------------------
// tra_pkg
// types, constants and helpers of the task run-time accounting block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tra_pkg;

    localparam int MAX_TASKS = 16;
    localparam int MAX_PROCS = 8;
    localparam int TIME_BITS = 32;

    localparam int OP_W    = 2;
    localparam int TASK_W  = 4;
    localparam int PROC_W  = 3;
    localparam int ACC_W   = 32;
    localparam int MOVE_W  = 16;
    localparam int TASK_AW = $clog2(MAX_TASKS);
    localparam int PROC_AW = $clog2(MAX_PROCS);

    localparam logic [OP_W-1:0] OP_PREEMPT = 2'd0;
    localparam logic [OP_W-1:0] OP_RESUME  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    typedef struct packed {
        logic [ACC_W-1:0]     run_total;
        logic [MOVE_W-1:0]    move_count;
        logic [TIME_BITS-1:0] resume_stamp;
        logic [TIME_BITS-1:0] preempt_stamp;
        logic [PROC_W-1:0]    home_proc;
        logic                 home_valid;
    } task_entry_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [TIME_BITS-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

@@ hw/rtl/task_runtime_accounting.sv @@
// ---------------------------------------------------------------------------
// task_runtime_accounting
// per-task run time, migration count and per-processor busy time accounting
// ---------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low; opcode,
//   task_id, proc_id and now are sampled on that edge.
//   preempt: task entry read-modify-write, then processor entry
//     read-modify-write, no result.
//   resume: task entry read-modify-write, no result.
//   read: one result beat, valid from the edge after the accepting one.
//   finish: 16 close-out steps, then 16 report steps with one result beat
//     each, last on slot 15.
//   The steps follow from the task and processor memories, whose read data
//   is registered: every step waits for the read data before writing back.
//   Results appear on the result ports for one cycle, marked by result_valid;
//   the receiver cannot stall and must take each beat as it comes.
//   Reset clears the state, the result strobe and all per-entry valid bits,
//   so each task and processor entry then reads as zero; no clearing pass runs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module task_runtime_accounting (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tra_pkg::OP_W-1:0]      opcode,
    input  logic [tra_pkg::TASK_W-1:0]    task_id,
    input  logic [tra_pkg::PROC_W-1:0]    proc_id,
    input  logic [tra_pkg::TIME_BITS-1:0] now,
    output logic                          result_valid,
    output logic [tra_pkg::TASK_W-1:0]    task_index,
    output logic                          task_known,
    output logic [tra_pkg::ACC_W-1:0]     exec_time,
    output logic [tra_pkg::MOVE_W-1:0]    migration_count,
    output logic [tra_pkg::ACC_W-1:0]     busy_time,
    output logic                          last
);
    import tra_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TASK  = 3'd1;
    localparam logic [2:0] S_PROC  = 3'd2;
    localparam logic [2:0] S_FRD   = 3'd3;
    localparam logic [2:0] S_ORD   = 3'd4;
    localparam logic [2:0] S_OTASK = 3'd5;
    localparam logic [2:0] S_OPROC = 3'd6;
    localparam logic [2:0] S_RDOUT = 3'd7;

    localparam logic [TASK_AW-1:0] LAST_SLOT = TASK_AW'(MAX_TASKS - 1);

    // memories
    task_entry_t          task_mem [MAX_TASKS];
    logic [ACC_W-1:0]     proc_mem [MAX_PROCS];
    task_entry_t          task_rd_reg;
    logic [ACC_W-1:0]     proc_rd_reg;

    logic                 task_we;
    logic [TASK_AW-1:0]   task_raddr;
    task_entry_t          task_wdata;
    logic                 proc_we;
    logic [PROC_AW-1:0]   proc_raddr;
    logic [ACC_W-1:0]     proc_wdata;

    // control and datapath registers
    logic [2:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [TASK_AW-1:0]   slot_reg, slot_next;
    logic [PROC_W-1:0]    proc_reg, proc_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [MAX_TASKS-1:0] known_reg, known_next;
    logic [MAX_PROCS-1:0] pvalid_reg, pvalid_next;
    logic                 known_rd_reg, known_rd_next;
    logic                 pvalid_rd_reg, pvalid_rd_next;
    logic [TIME_BITS-1:0] delta_reg, delta_next;
    logic [PROC_AW-1:0]   home_reg, home_next;
    logic                 charge_reg, charge_next;

    logic                 strobe_reg, strobe_next;
    logic [TASK_W-1:0]    index_reg, index_next;
    logic                 kout_reg, kout_next;
    logic [ACC_W-1:0]     exec_reg, exec_next;
    logic [MOVE_W-1:0]    mig_reg, mig_next;
    logic [ACC_W-1:0]     busy_reg, busy_next;
    logic                 last_reg, last_next;

    task_entry_t          entry;
    logic [ACC_W-1:0]     pentry;
    logic [TIME_BITS-1:0] delta;
    logic                 running;
    logic                 accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // entries never written read as zero
    assign entry   = known_rd_reg ? task_rd_reg : '0;
    assign pentry  = pvalid_rd_reg ? proc_rd_reg : '0;
    assign delta   = now_reg - entry.resume_stamp;
    assign running = known_rd_reg && (entry.resume_stamp >= entry.preempt_stamp);

    always_ff @(posedge clk)
    begin
        if (task_we)
        begin
            task_mem[slot_reg] <= task_wdata;
        end
        task_rd_reg <= task_mem[task_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (proc_we)
        begin
            proc_mem[home_reg] <= proc_wdata;
        end
        proc_rd_reg <= proc_mem[proc_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        proc_next      = proc_reg;
        now_next       = now_reg;
        known_next     = known_reg;
        pvalid_next    = pvalid_reg;
        delta_next     = delta_reg;
        home_next      = home_reg;
        charge_next    = charge_reg;
        strobe_next    = 1'b0;
        index_next     = index_reg;
        kout_next      = kout_reg;
        exec_next      = exec_reg;
        mig_next       = mig_reg;
        busy_next      = busy_reg;
        last_next      = last_reg;
        task_we        = 1'b0;
        task_wdata     = entry;
        proc_we        = 1'b0;
        proc_wdata     = sat_add(pentry, delta_reg);
        task_raddr     = slot_reg;
        proc_raddr     = home_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                task_raddr = task_id;
                proc_raddr = proc_id;
                if (accept)
                begin
                    op_next   = opcode;
                    slot_next = task_id;
                    proc_next = proc_id;
                    now_next  = now;
                    unique case (opcode)
                        OP_PREEMPT, OP_RESUME: state_next = S_TASK;
                        OP_FINISH:
                        begin
                            slot_next  = '0;
                            state_next = S_FRD;
                        end
                        default: state_next = S_RDOUT;
                    endcase
                end
            end
            S_TASK:
            begin
                proc_raddr  = entry.home_proc;
                home_next   = entry.home_proc;
                delta_next  = delta;
                priority case (op_reg)
                    OP_PREEMPT:
                    begin
                        task_we                  = 1'b1;
                        task_wdata.run_total     = sat_add(entry.run_total, delta);
                        task_wdata.preempt_stamp = now_reg;
                        known_next[slot_reg]     = 1'b1;
                        charge_next              = entry.home_valid;
                        state_next               = S_PROC;
                    end
                    OP_RESUME:
                    begin
                        task_we                 = 1'b1;
                        task_wdata.resume_stamp = now_reg;
                        if (!entry.home_valid || entry.home_proc != proc_reg)
                        begin
                            task_wdata.home_proc  = proc_reg;
                            task_wdata.home_valid = 1'b1;
                            if (entry.move_count != {MOVE_W{1'b1}})
                            begin
                                task_wdata.move_count = entry.move_count + 1'b1;
                            end
                        end
                        known_next[slot_reg] = 1'b1;
                        state_next           = S_IDLE;
                    end
                    default:
                    begin
                        // finish close-out: stamps stay as they are
                        task_we              = running;
                        task_wdata.run_total = sat_add(entry.run_total, delta);
                        charge_next          = running && entry.home_valid;
                        state_next           = S_PROC;
                    end
                endcase
            end
            S_PROC:
            begin
                if (charge_reg)
                begin
                    proc_we               = 1'b1;
                    pvalid_next[home_reg] = 1'b1;
                end
                if (op_reg == OP_FINISH)
                begin
                    if (slot_reg == LAST_SLOT)
                    begin
                        slot_next  = '0;
                        state_next = S_ORD;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_FRD;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_TASK;
            end
            S_ORD:
            begin
                state_next = S_OTASK;
            end
            S_OTASK:
            begin
                proc_raddr  = entry.home_proc;
                home_next   = entry.home_proc;
                charge_next = entry.home_valid;
                index_next  = slot_reg;
                kout_next   = known_rd_reg;
                exec_next   = entry.run_total;
                mig_next    = entry.move_count;
                state_next  = S_OPROC;
            end
            S_OPROC:
            begin
                strobe_next = 1'b1;
                busy_next   = charge_reg ? pentry : '0;
                last_next   = (slot_reg == LAST_SLOT);
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_ORD;
                end
            end
            default:
            begin
                // processor busy-time read
                strobe_next = 1'b1;
                index_next  = '0;
                kout_next   = 1'b0;
                exec_next   = '0;
                mig_next    = '0;
                busy_next   = pentry;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
        endcase

        known_rd_next  = known_reg[task_raddr];
        pvalid_rd_next = pvalid_reg[proc_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            known_reg     <= '0;
            pvalid_reg    <= '0;
            known_rd_reg  <= 1'b0;
            pvalid_rd_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            known_reg     <= known_next;
            pvalid_reg    <= pvalid_next;
            known_rd_reg  <= known_rd_next;
            pvalid_rd_reg <= pvalid_rd_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        proc_reg   <= proc_next;
        now_reg    <= now_next;
        delta_reg  <= delta_next;
        home_reg   <= home_next;
        charge_reg <= charge_next;
        index_reg  <= index_next;
        kout_reg   <= kout_next;
        exec_reg   <= exec_next;
        mig_reg    <= mig_next;
        busy_reg   <= busy_next;
        last_reg   <= last_next;
    end

    assign result_valid    = strobe_reg;
    assign task_index      = index_reg;
    assign task_known      = kout_reg;
    assign exec_time       = exec_reg;
    assign migration_count = mig_reg;
    assign busy_time       = busy_reg;
    assign last            = last_reg;

    `CHK_NEXT(a_accept_busy, clk, rst_n, accept, busy, "accepted command did not raise busy")
    `CHK_NEXT(a_beat_spacing, clk, rst_n, result_valid, !result_valid, "result beats back to back")
    `CHK_IMPLY(a_more_pending, clk, rst_n, result_valid && !last, busy, "idle with beats pending")
    `CHK_IMPLY(a_proc_write_charge, clk, rst_n, proc_we, charge_reg && (state_reg == S_PROC), "stray processor write")

endmodule

@@ tb/task_runtime_accounting_test.sv @@
// ---------------------------------------------------------------------------
// task_runtime_accounting_test
// self-checking regression of the task run-time accounting block: commands
// go in through the start/busy handshake, each result beat is compared with
// an in-bench prediction of task run time, migrations and processor busy time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_runtime_accounting_test;

    localparam int NUM_TASKS   = 16;
    localparam int NUM_PROCS   = 8;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MOVE_STEPS  = 9;

    typedef struct packed {
        logic [tra_pkg::TASK_W-1:0] idx;
        logic                       known;
        logic [tra_pkg::ACC_W-1:0]  exec;
        logic [tra_pkg::MOVE_W-1:0] moves;
        logic [tra_pkg::ACC_W-1:0]  busy;
        logic                       is_last;
    } report_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [tra_pkg::OP_W-1:0]      opcode;
    logic [tra_pkg::TASK_W-1:0]    task_id;
    logic [tra_pkg::PROC_W-1:0]    proc_id;
    logic [tra_pkg::TIME_BITS-1:0] now;
    logic                          result_valid;
    logic [tra_pkg::TASK_W-1:0]    task_index;
    logic                          task_known;
    logic [tra_pkg::ACC_W-1:0]     exec_time;
    logic [tra_pkg::MOVE_W-1:0]    migration_count;
    logic [tra_pkg::ACC_W-1:0]     busy_time;
    logic                          last;

    // predicted accounting state
    logic                          task_seen  [NUM_TASKS];
    logic [tra_pkg::ACC_W-1:0]     task_run   [NUM_TASKS];
    logic [tra_pkg::MOVE_W-1:0]    task_moves [NUM_TASKS];
    logic [tra_pkg::TIME_BITS-1:0] resume_at  [NUM_TASKS];
    logic [tra_pkg::TIME_BITS-1:0] preempt_at [NUM_TASKS];
    logic [tra_pkg::PROC_W-1:0]    home_cpu   [NUM_TASKS];
    logic                          home_set   [NUM_TASKS];
    logic [tra_pkg::ACC_W-1:0]     cpu_busy   [NUM_PROCS];

    report_t pending_reports[$];
    report_t want;

    int  mismatches = 0;
    int  cmds_sent = 0;
    int  reports_seen = 0;
    int  finishes_sent = 0;
    int  reads_sent = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    logic [tra_pkg::TIME_BITS-1:0] clock_now = '0;

    task_runtime_accounting dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .task_id         (task_id),
        .proc_id         (proc_id),
        .now             (now),
        .result_valid    (result_valid),
        .task_index      (task_index),
        .task_known      (task_known),
        .exec_time       (exec_time),
        .migration_count (migration_count),
        .busy_time       (busy_time),
        .last            (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_reports.size());
            $display("task_runtime_accounting regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic clear_model();
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            task_seen[i]  = 1'b0;
            task_run[i]   = '0;
            task_moves[i] = '0;
            resume_at[i]  = '0;
            preempt_at[i] = '0;
            home_cpu[i]   = '0;
            home_set[i]   = 1'b0;
        end
        for (int i = 0; i < NUM_PROCS; i++)
            cpu_busy[i] = '0;
    endtask

    // run time since last resume goes to the task and to its processor
    task automatic charge_task(input int t, input logic [31:0] at);
        logic [31:0] delta;
        delta = at - resume_at[t];
        task_run[t] = add_clamped(task_run[t], delta);
        if (home_set[t])
            cpu_busy[home_cpu[t]] = add_clamped(cpu_busy[home_cpu[t]], delta);
    endtask

    task automatic predict_accounting(input logic [1:0] op, input logic [3:0] tid,
                                      input logic [2:0] pid, input logic [31:0] at);
        report_t r;
        case (op)
            tra_pkg::OP_PREEMPT:
            begin
                task_seen[tid] = 1'b1;
                charge_task(int'(tid), at);
                preempt_at[tid] = at;
            end
            tra_pkg::OP_RESUME:
            begin
                task_seen[tid] = 1'b1;
                resume_at[tid] = at;
                if (!home_set[tid] || home_cpu[tid] != pid)
                begin
                    home_cpu[tid] = pid;
                    home_set[tid] = 1'b1;
                    if (task_moves[tid] != 16'hFFFF)
                        task_moves[tid] = task_moves[tid] + 1'b1;
                end
            end
            tra_pkg::OP_FINISH:
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                    if (task_seen[i] && resume_at[i] >= preempt_at[i])
                        charge_task(i, at);
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    r.idx     = 4'(i);
                    r.known   = task_seen[i];
                    r.exec    = task_run[i];
                    r.moves   = task_moves[i];
                    r.busy    = home_set[i] ? cpu_busy[home_cpu[i]] : '0;
                    r.is_last = (i == NUM_TASKS - 1);
                    pending_reports.push_back(r);
                end
            end
            default:
            begin
                r = '0;
                r.busy    = cpu_busy[pid];
                r.is_last = 1'b1;
                pending_reports.push_back(r);
            end
        endcase
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [3:0] tid,
                            input logic [2:0] pid, input logic [31:0] at);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        opcode  <= op;
        task_id <= tid;
        proc_id <= pid;
        now     <= at;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_accounting(op, tid, pid, at);
        cmds_sent++;
        if (op == tra_pkg::OP_FINISH)
            finishes_sent++;
        if (op == tra_pkg::OP_READ)
            reads_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: unexpected result beat, expected none, actual slot %0h",
                             $time, task_index);
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("task_index", 32'(want.idx), 32'(task_index));
                compare_field("task_known", 32'(want.known), 32'(task_known));
                compare_field("exec_time", want.exec, exec_time);
                compare_field("migration_count", 32'(want.moves), 32'(migration_count));
                compare_field("busy_time", want.busy, busy_time);
                compare_field("last", 32'(want.is_last), 32'(last));
            end
        end
    end

    // finish and reads straight out of reset: everything zero, nothing known
    task automatic test_after_reset();
        send_cmd(tra_pkg::OP_FINISH, 4'd0, 3'd0, 32'd0);
        send_cmd(tra_pkg::OP_READ, 4'd0, 3'd0, 32'hFFFF_FFFF);
        send_cmd(tra_pkg::OP_READ, 4'd15, 3'd7, 32'd0);
    endtask

    task automatic test_extremes();
        send_cmd(tra_pkg::OP_RESUME, 4'd0, 3'd7, 32'd0);
        // full-range delta fills task and processor totals, the next delta saturates them
        send_cmd(tra_pkg::OP_PREEMPT, 4'd0, 3'd0, 32'hFFFF_FFFF);
        send_cmd(tra_pkg::OP_RESUME, 4'd0, 3'd7, 32'd5);
        send_cmd(tra_pkg::OP_PREEMPT, 4'd0, 3'd7, 32'd10);
        send_cmd(tra_pkg::OP_READ, 4'd0, 3'd7, 32'd11);
        // delta across the time wrap
        send_cmd(tra_pkg::OP_RESUME, 4'd15, 3'd0, 32'hFFFF_FFF0);
        send_cmd(tra_pkg::OP_PREEMPT, 4'd15, 3'd0, 32'h0000_0010);
        // preempt of a task never resumed: no processor to charge
        send_cmd(tra_pkg::OP_PREEMPT, 4'd3, 3'd5, 32'd100);
        send_cmd(tra_pkg::OP_READ, 4'd9, 3'd0, 32'd0);
        send_cmd(tra_pkg::OP_RESUME, 4'd12, 3'd4, 32'd77);
        send_cmd(tra_pkg::OP_PREEMPT, 4'd12, 3'd4, 32'd77);
    endtask

    task automatic test_close_out();
        send_cmd(tra_pkg::OP_RESUME, 4'd5, 3'd2, 32'd50);
        send_cmd(tra_pkg::OP_RESUME, 4'd5, 3'd6, 32'd60);
        send_cmd(tra_pkg::OP_READ, 4'd10, 3'd5, 32'hAAAA_5555);
        send_cmd(tra_pkg::OP_FINISH, 4'd7, 3'd3, 32'd200);
        // stamps stay put, so a second finish charges running tasks again
        send_cmd(tra_pkg::OP_FINISH, 4'd0, 3'd0, 32'd300);
        send_cmd(tra_pkg::OP_READ, 4'd0, 3'd6, 32'd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int          roll;
        logic [3:0]  tid;
        logic [2:0]  pid;
        logic [1:0]  op;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            tid  = 4'($urandom_range(0, NUM_TASKS - 1));
            pid  = 3'($urandom_range(0, NUM_PROCS - 1));
            clock_now = clock_now + $urandom_range(0, 3000);
            if ($urandom_range(0, 24) == 0)
                clock_now = clock_now + $urandom;
            if (roll < 60)
            begin
                // well-formed resume/preempt alternation per task
                if (task_seen[tid] && resume_at[tid] >= preempt_at[tid])
                    send_cmd(tra_pkg::OP_PREEMPT, tid, pid, clock_now);
                else
                begin
                    if (home_set[tid] && $urandom_range(0, 3) != 0)
                        pid = home_cpu[tid];
                    send_cmd(tra_pkg::OP_RESUME, tid, pid, clock_now);
                end
            end
            else if (roll < 70)
            begin
                send_cmd(tra_pkg::OP_FINISH, tid, pid, clock_now);
                if (k > n_items / 2 && $urandom_range(0, 2) == 0)
                    hold_until_drained();
            end
            else if (roll < 85)
                send_cmd(tra_pkg::OP_READ, tid, pid, $urandom);
            else
            begin
                op = $urandom_range(0, 1) ? tra_pkg::OP_RESUME : tra_pkg::OP_PREEMPT;
                send_cmd(op, tid, pid, $urandom);
            end
        end
        no_idle = 1'b0;
    endtask

    // sender holds off until every result of a finish has come back
    task automatic test_pause_on_drain();
        send_cmd(tra_pkg::OP_FINISH, 4'd2, 3'd1, clock_now);
        hold_until_drained();
        send_cmd(tra_pkg::OP_READ, 4'd0, 3'd1, 32'd0);
        hold_until_drained();
    endtask

    // alternate processors on one task back to back, each change is a migration
    task automatic test_migration_moves();
        no_idle = 1'b1;
        for (int k = 0; k < MOVE_STEPS; k++)
            send_cmd(tra_pkg::OP_RESUME, 4'd9, (k % 2) ? 3'd1 : 3'd2, clock_now + k);
        no_idle = 1'b0;
        send_cmd(tra_pkg::OP_PREEMPT, 4'd9, 3'd0, clock_now + MOVE_STEPS + 100);
        send_cmd(tra_pkg::OP_FINISH, 4'd9, 3'd0, clock_now + MOVE_STEPS + 200);
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        opcode  = tra_pkg::OP_PREEMPT;
        task_id = '0;
        proc_id = '0;
        now     = '0;
        clear_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_extremes();
        test_close_out();
        test_random_traffic(170);
        test_pause_on_drain();
        test_random_traffic(180);
        test_migration_moves();

        hold_until_drained();
        repeat (120) @(posedge clk);

        $display("covered %0d commands: %0d finish, %0d read, rest preempt/resume",
                 cmds_sent, finishes_sent, reads_sent);
        $display("checked %0d result beats incl. saturation, time wrap and migrations",
                 reports_seen);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("task_runtime_accounting regression: pass");
        else
            $display("task_runtime_accounting regression: fail");
        $finish;
    end

endmodule
